@@ design/lmsh_pkg.sv @@
`timescale 1ns / 1ps

package lmsh_pkg;

   localparam int DEF_NUM_BINS    = 40;
   localparam int DEF_COUNT_WIDTH = 32;

   localparam int SIZE_WIDTH  = 64;
   localparam int CODE_WIDTH  = 8;
   localparam int RBIN_WIDTH  = 6;
   localparam int OUT_WIDTH   = 32;
   localparam int MASK_WORDS  = 4;
   localparam int MASK_WIDTH  = 64;
   localparam int CSR_IDX_W   = 2;

   // result queue depth, covers the read latency of the lanes
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // per-request control handed to both lanes
   typedef struct packed {
      logic record;   // record request whose filter bit is set
      logic read;
      logic clear;
   } lmsh_ctrl_type;

endpackage

@@ design/log2_message_size_histogram.sv @@
`timescale 1ns / 1ps

// Send and receive message-size histograms. A record request whose call code
// is selected by the 256-bit filter mask adds one to bin ceil(log2 size) of
// each histogram for every positive size (bins clamp to the last, counters
// saturate); a read request returns both counts of one bin, zero beyond the
// last bin; a clear request zeroes both histograms. One request is taken per
// clock while req_tready is high; the two histograms are separate lanes, each
// a two-stage pipeline of size decode with counter read, then saturating
// write-back, and read results go through an output queue. req_tready falls
// only while four read responses are in flight or waiting in the output queue.
module log2_message_size_histogram #(
   parameter int NUM_BINS    = lmsh_pkg::DEF_NUM_BINS,
   parameter int COUNT_WIDTH = lmsh_pkg::DEF_COUNT_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // call_code[7:0], sent_size[71:8], received_size[135:72], read_bin[141:136]
   input  logic [143:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // send_count[31:0], recv_count[63:32]
   output logic [63:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [lmsh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lmsh_pkg::MASK_WIDTH-1:0] csr_wdata
);
   import lmsh_pkg::*;

   logic [MASK_WORDS*MASK_WIDTH-1:0] mask_ff;
   logic                   accept;
   logic [CODE_WIDTH-1:0]  call_code;
   logic [SIZE_WIDTH-1:0]  sent_size;
   logic [SIZE_WIDTH-1:0]  received_size;
   logic [RBIN_WIDTH-1:0]  read_bin;
   lmsh_ctrl_type          ctrl;
   logic                   send_valid, recv_valid;
   logic [OUT_WIDTH-1:0]   send_count, recv_count;

   assign call_code     = req_tdata[7:0];
   assign sent_size     = req_tdata[71:8];
   assign received_size = req_tdata[135:72];
   assign read_bin      = req_tdata[141:136];

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_wr_en) begin
         mask_ff[csr_index*MASK_WIDTH +: MASK_WIDTH] <= csr_wdata;
      end
   end

   assign ctrl.record = (req_tuser == OP_RECORD) && mask_ff[call_code];
   assign ctrl.read   = (req_tuser == OP_READ);
   assign ctrl.clear  = (req_tuser == OP_CLEAR);

   lmsh_lane #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_send_lane (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_ctrl     (ctrl),
      .in_size     (sent_size),
      .in_read_bin (read_bin),
      .out_valid   (send_valid),
      .out_count   (send_count)
   );

   lmsh_lane #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_recv_lane (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_ctrl     (ctrl),
      .in_size     (received_size),
      .in_read_bin (read_bin),
      .out_valid   (recv_valid),
      .out_count   (recv_count)
   );

   lmsh_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .read_accept (accept && ctrl.read),
      .can_accept  (req_tready),
      .send_valid  (send_valid),
      .send_count  (send_count),
      .recv_valid  (recv_valid),
      .recv_count  (recv_count),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

@@ design/lmsh_lane.sv @@
`timescale 1ns / 1ps

module lmsh_lane #(
   parameter int NUM_BINS    = lmsh_pkg::DEF_NUM_BINS,
   parameter int COUNT_WIDTH = lmsh_pkg::DEF_COUNT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  lmsh_pkg::lmsh_ctrl_type           in_ctrl,
   input  logic [lmsh_pkg::SIZE_WIDTH-1:0]   in_size,
   input  logic [lmsh_pkg::RBIN_WIDTH-1:0]   in_read_bin,
   output logic                              out_valid,
   output logic [lmsh_pkg::OUT_WIDTH-1:0]    out_count
);
   import lmsh_pkg::*;

   localparam int BIN_WIDTH = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int LEN_WIDTH = $clog2(SIZE_WIDTH + 1);
   localparam logic [LEN_WIDTH-1:0] LAST_BIN = LEN_WIDTH'(NUM_BINS - 1);
   localparam logic [RBIN_WIDTH:0] BIN_LIMIT = (RBIN_WIDTH + 1)'(NUM_BINS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                    pos;
   logic [SIZE_WIDTH-1:0]   dec;

   logic                    s1_rec_ff, s1_rec_in;
   logic                    s1_read_ff, s1_read_in;
   logic                    s1_clear_ff, s1_clear_in;
   logic [SIZE_WIDTH-1:0]   s1_dec_ff;
   logic [RBIN_WIDTH-1:0]   s1_rbin_ff;

   logic [LEN_WIDTH-1:0]    bit_len;
   logic [BIN_WIDTH-1:0]    bin;
   logic [BIN_WIDTH-1:0]    rd_addr;
   logic                    rd_oob;

   logic [COUNT_WIDTH-1:0]  hist_mem [NUM_BINS];
   logic [NUM_BINS-1:0]     valid_ff, valid_in;

   logic                    s2_rec_ff, s2_read_ff, s2_clear_ff;
   logic [BIN_WIDTH-1:0]    s2_addr_ff;
   logic                    s2_oob_ff;
   logic [COUNT_WIDTH-1:0]  s2_mem_ff;
   logic                    s2_vld_ff;

   logic                    prev_wr_ff, prev_clear_ff;
   logic [BIN_WIDTH-1:0]    prev_addr_ff;
   logic [COUNT_WIDTH-1:0]  prev_data_ff;

   logic [COUNT_WIDTH-1:0]  cur;
   logic [COUNT_WIDTH-1:0]  nxt;

   // input stage: only positive sizes count
   assign pos = !in_size[SIZE_WIDTH-1] && (in_size != '0);
   assign dec = in_size - SIZE_WIDTH'(1);

   assign s1_rec_in   = in_valid && in_ctrl.record && pos;
   assign s1_read_in  = in_valid && in_ctrl.read;
   assign s1_clear_in = in_valid && in_ctrl.clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_rec_ff   <= 1'b0;
         s1_read_ff  <= 1'b0;
         s1_clear_ff <= 1'b0;
      end else begin
         s1_rec_ff   <= s1_rec_in;
         s1_read_ff  <= s1_read_in;
         s1_clear_ff <= s1_clear_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_dec_ff  <= dec;
      s1_rbin_ff <= in_read_bin;
   end

   // bin is the bit length of size - 1, clamped to the last bin
   always_comb begin
      bit_len = '0;
      for (int i = 0; i < SIZE_WIDTH; i++) begin
         if (s1_dec_ff[i]) bit_len = LEN_WIDTH'(i + 1);
      end
   end

   assign bin     = (bit_len > LAST_BIN) ? LAST_BIN[BIN_WIDTH-1:0] : bit_len[BIN_WIDTH-1:0];
   assign rd_oob  = ({1'b0, s1_rbin_ff} >= BIN_LIMIT);
   assign rd_addr = s1_read_ff ? s1_rbin_ff[BIN_WIDTH-1:0] : bin;

   always_ff @(posedge clock) begin
      s2_mem_ff    <= hist_mem[rd_addr];
      s2_vld_ff    <= valid_ff[rd_addr];
      s2_addr_ff   <= rd_addr;
      s2_oob_ff    <= rd_oob;
      prev_addr_ff <= s2_addr_ff;
      prev_data_ff <= nxt;
      if (s2_rec_ff) hist_mem[s2_addr_ff] <= nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_rec_ff     <= 1'b0;
         s2_read_ff    <= 1'b0;
         s2_clear_ff   <= 1'b0;
         prev_wr_ff    <= 1'b0;
         prev_clear_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         s2_rec_ff     <= s1_rec_ff;
         s2_read_ff    <= s1_read_ff;
         s2_clear_ff   <= s1_clear_ff;
         prev_wr_ff    <= s2_rec_ff;
         prev_clear_ff <= s2_clear_ff;
         valid_ff      <= valid_in;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (s2_clear_ff) valid_in = '0;
      else if (s2_rec_ff) valid_in[s2_addr_ff] = 1'b1;
   end

   // bypass the update or clear that landed as this entry was read
   always_comb begin
      if (prev_clear_ff) cur = '0;
      else if (prev_wr_ff && (prev_addr_ff == s2_addr_ff)) cur = prev_data_ff;
      else if (s2_vld_ff) cur = s2_mem_ff;
      else cur = '0;
   end

   assign nxt = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

   assign out_valid = s2_read_ff;
   assign out_count = s2_oob_ff ? '0 : OUT_WIDTH'(cur);

endmodule

@@ design/lmsh_merge.sv @@
`timescale 1ns / 1ps

module lmsh_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             read_accept,
   output logic                             can_accept,
   input  logic                             send_valid,
   input  logic [lmsh_pkg::OUT_WIDTH-1:0]   send_count,
   input  logic                             recv_valid,
   input  logic [lmsh_pkg::OUT_WIDTH-1:0]   recv_count,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [2*lmsh_pkg::OUT_WIDTH-1:0] rsp_tdata
);
   import lmsh_pkg::*;

   logic [2*OUT_WIDTH-1:0] queue_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   fill_ff, fill_in;
   logic [RSP_CNT_W-1:0]   resv_ff, resv_in;
   logic                   push, pop;

   assign push = send_valid && recv_valid;
   assign pop  = rsp_tvalid && rsp_tready;

   // a slot is reserved for each read request still in the lanes
   assign can_accept = (resv_ff < RSP_CNT_W'(RSP_DEPTH));

   assign wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
   assign fill_in   = fill_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   assign resv_in   = resv_ff + RSP_CNT_W'(read_accept) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         resv_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         resv_ff   <= resv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_mem[wr_ptr_ff] <= {recv_count, send_count};
   end

   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = queue_mem[rd_ptr_ff];

endmodule
